// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the compensation RTL.
// Included by bptc_mul.sv and baro_pressure_temp_compensation.sv; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property, checked at every clock edge outside reset
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)
`endif
`endif

// ===== rtl/core/bptc_pkg.sv =====
// Shared widths, codes and constants for the barometric compensation block.
// No dependencies; imported by bptc_mul, the top level, bptc_result_check and the testbench.
`default_nettype none

package bptc_pkg;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 16;
  localparam int CMD_W    = 8;
  localparam int TEMP_W   = 19;
  localparam int PRES_W   = 22;
  localparam int CFG_IDX_W = 3;

  // Internal arithmetic widths
  localparam int DT_W     = SAMPLE_W + 1;     // raw temperature minus scaled reference
  localparam int MCAND_W  = 35;               // signed multiplicand: dT or SENS
  localparam int MPLIER_W = SAMPLE_W;         // unsigned multiplier: coefficient or D1
  localparam int ACC_W    = 60;               // product accumulator
  localparam int OFF_W    = 36;

  // Radix-4 serial multiplier
  localparam int MUL_DIGITS = MPLIER_W / 2;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

  // Conversion commands
  localparam logic [CMD_W-1:0] CMD_CONVERT_TEMP     = 8'h58;
  localparam logic [CMD_W-1:0] CMD_CONVERT_PRESSURE = 8'h48;

  // Compensation constants (shifts are log2 of the scale factors)
  localparam int TEMP_BASE    = 2000;
  localparam int REF_SHIFT    = 8;
  localparam int TEMP_SHIFT   = 23;
  localparam int OFF_SHIFT    = 16;
  localparam int OFF_T_SHIFT  = 7;
  localparam int SENS_SHIFT   = 15;
  localparam int SENS_T_SHIFT = 8;
  localparam int P1_SHIFT     = 21;
  localparam int P2_SHIFT     = 15;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

endpackage

`default_nettype wire

// ===== rtl/core/bptc_mul.sv =====
// Radix-4 digit-serial signed-by-unsigned multiplier, two multiplier bits per cycle.
// Depends on bptc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bptc_mul
  import bptc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [MCAND_W-1:0]  mcand,
  input  wire logic        [MPLIER_W-1:0] mplier,
  output logic                            done,
  output logic signed [ACC_W-1:0]         product
);

  logic signed [ACC_W-1:0]  m1;
  logic signed [ACC_W-1:0]  m3;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  mcand_ext;
  logic [MPLIER_W-1:0]      mq;
  logic [MUL_CNT_W-1:0]     cnt;
  logic                     running;

  assign mcand_ext = {{(ACC_W-MCAND_W){mcand[MCAND_W-1]}}, mcand};

  // Partial product for the current digit
  always_comb begin
    case (mq[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = m1;
      2'd2:    addend = m1 <<< 1;
      2'd3:    addend = m3;
      default: addend = '0;
    endcase
  end

  // Control: run for one pass of all digits
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + MUL_CNT_W'(1);
        if (cnt == MUL_CNT_W'(MUL_DIGITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: multiplicand shifts up a digit, multiplier shifts down a digit
  always_ff @(posedge clk) begin
    if (start) begin
      m1  <= mcand_ext;
      m3  <= mcand_ext + (mcand_ext <<< 1);
      mq  <= mplier;
      acc <= '0;
    end else if (running) begin
      m1  <= m1 <<< 2;
      m3  <= m3 <<< 2;
      mq  <= mq >> 2;
      acc <= acc + addend;
    end
  end

  assign product = acc;

  `ASSERT_AT(a_done_after_run, clk, rst, done |-> $past(running), "done without a pass")
  `ASSERT_NEVER(a_start_while_busy, clk, rst, start && running, "start while busy")
  `ASSERT_AT(a_run_from_start, clk, rst, $rose(running) |-> $past(start), "run without start")

endmodule

`default_nettype wire

// ===== rtl/core/baro_pressure_temp_compensation.sv =====
// Top level: barometric first-order temperature and pressure compensation.
// Depends on bptc_pkg, bptc_mul and assert_macros.svh.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  input    | in_valid / in_ready   | adc_sample[23:0]
//  output   | out_valid / out_ready | next_command, sample_was_pressure,
//           |                       | temp_centideg, pressure_pa
//  config   | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[15:0] (ready always high)
//
// Each request makes four passes of the shared radix-4 multiplier (12 digits a pass):
// dT*C6, dT*C4, dT*C3, D1*SENS. After the passes come S_FIN and S_PUSH, which writes the
// output register; the next request is taken back in S_IDLE, so requests do not overlap.
// Reset clears the phase, both raw slots and all six calibration words.
// A waiting result sits in the output register; the block stalls at its end only if the
// previous result has still not been taken.
`default_nettype none
`include "assert_macros.svh"

module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [SAMPLE_W-1:0]      adc_sample,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [CMD_W-1:0]              next_command,
  output logic                          sample_was_pressure,
  output logic signed [TEMP_W-1:0]      temp_centideg,
  output logic signed [PRES_W-1:0]      pressure_pa,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [COEF_W-1:0]        cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_WAIT = 5'b00100,
    S_FIN  = 5'b01000,
    S_PUSH = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PASS_TEMP = 2'd0,
    PASS_OFF  = 2'd1,
    PASS_SENS = 2'd2,
    PASS_PRES = 2'd3
  } pass_t;

  // Truncating signed divide by 2^k
  function automatic logic signed [ACC_W-1:0] div_pow2(input logic signed [ACC_W-1:0] x,
                                                       input int unsigned k);
    logic signed [ACC_W-1:0] bias;
    bias = x[ACC_W-1] ? $signed((ACC_W'(1) << k) - ACC_W'(1)) : '0;
    return (x + bias) >>> k;
  endfunction

  state_t state;
  pass_t  pass;

  // Calibration words
  logic [COEF_W-1:0] sens_coef;
  logic [COEF_W-1:0] offset_coef;
  logic [COEF_W-1:0] sens_temp_coef;
  logic [COEF_W-1:0] offset_temp_coef;
  logic [COEF_W-1:0] ref_temp_word;
  logic [COEF_W-1:0] temp_slope_coef;

  // Sample state
  logic                pressure_phase;
  logic [SAMPLE_W-1:0] raw_pressure;
  logic [SAMPLE_W-1:0] raw_temperature;
  logic [SAMPLE_W-1:0] raw_temperature_next;

  // Working registers
  logic signed [DT_W-1:0]    dt;
  logic signed [DT_W-1:0]    dt_next;
  logic signed [TEMP_W-1:0]  temp_w;
  logic signed [OFF_W-1:0]   off_w;
  logic signed [MCAND_W-1:0] sens_w;
  logic signed [ACC_W-1:0]   diff_w;
  logic signed [PRES_W-1:0]  pres_w;
  logic [CMD_W-1:0]          cmd_w;
  logic                      was_pres_w;

  // Multiplier hookup
  logic                       mul_start;
  logic signed [MCAND_W-1:0]  mul_mcand;
  logic        [MPLIER_W-1:0] mul_mplier;
  logic                       mul_done;
  logic signed [ACC_W-1:0]    mul_product;
  logic signed [ACC_W-1:0]    prod_scaled;
  logic signed [ACC_W-1:0]    base_term;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mul_start = (state == S_LOAD);

  // dT from the slot value this request leaves behind
  assign raw_temperature_next = pressure_phase ? raw_temperature : adc_sample;
  assign dt_next = $signed({1'b0, raw_temperature_next})
                 - $signed({1'b0, ref_temp_word, {REF_SHIFT{1'b0}}});

  // Operand select per pass
  always_comb begin
    case (pass)
      PASS_TEMP: begin
        mul_mcand  = {{(MCAND_W-DT_W){dt[DT_W-1]}}, dt};
        mul_mplier = MPLIER_W'(temp_slope_coef);
      end
      PASS_OFF: begin
        mul_mcand  = {{(MCAND_W-DT_W){dt[DT_W-1]}}, dt};
        mul_mplier = MPLIER_W'(offset_temp_coef);
      end
      PASS_SENS: begin
        mul_mcand  = {{(MCAND_W-DT_W){dt[DT_W-1]}}, dt};
        mul_mplier = MPLIER_W'(sens_temp_coef);
      end
      PASS_PRES: begin
        mul_mcand  = sens_w;
        mul_mplier = raw_pressure;
      end
      default: begin
        mul_mcand  = '0;
        mul_mplier = '0;
      end
    endcase
  end

  // Scale the product and pick the term it combines with
  always_comb begin
    case (pass)
      PASS_TEMP: begin
        prod_scaled = div_pow2(mul_product, TEMP_SHIFT);
        base_term   = ACC_W'(TEMP_BASE);
      end
      PASS_OFF: begin
        prod_scaled = div_pow2(mul_product, OFF_T_SHIFT);
        base_term   = $signed(ACC_W'(offset_coef) << OFF_SHIFT);
      end
      PASS_SENS: begin
        prod_scaled = div_pow2(mul_product, SENS_T_SHIFT);
        base_term   = $signed(ACC_W'(sens_coef) << SENS_SHIFT);
      end
      PASS_PRES: begin
        prod_scaled = div_pow2(mul_product, P1_SHIFT);
        base_term   = -{{(ACC_W-OFF_W){off_w[OFF_W-1]}}, off_w};
      end
      default: begin
        prod_scaled = '0;
        base_term   = '0;
      end
    endcase
  end

  bptc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_product)
  );

  // Configuration writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coef        <= '0;
      offset_coef      <= '0;
      sens_temp_coef   <= '0;
      offset_temp_coef <= '0;
      ref_temp_word    <= '0;
      temp_slope_coef  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SENS:        sens_coef        <= cfg_data;
        REG_OFFSET:      offset_coef      <= cfg_data;
        REG_SENS_TEMP:   sens_temp_coef   <= cfg_data;
        REG_OFFSET_TEMP: offset_temp_coef <= cfg_data;
        REG_REF_TEMP:    ref_temp_word    <= cfg_data;
        REG_TEMP_SLOPE:  temp_slope_coef  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and sample slots
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pass            <= PASS_TEMP;
      pressure_phase  <= 1'b0;
      raw_pressure    <= '0;
      raw_temperature <= '0;
      out_valid       <= 1'b0;
    end else begin
      // result taken; a push in the same cycle refills it below
      if (out_valid && out_ready && state != S_PUSH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (pressure_phase) begin
              raw_pressure <= adc_sample;
            end else begin
              raw_temperature <= adc_sample;
            end
            pressure_phase <= !pressure_phase;
            pass           <= PASS_TEMP;
            state          <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            case (pass)
              PASS_TEMP: begin pass <= PASS_OFF;  state <= S_LOAD; end
              PASS_OFF:  begin pass <= PASS_SENS; state <= S_LOAD; end
              PASS_SENS: begin pass <= PASS_PRES; state <= S_LOAD; end
              PASS_PRES: begin state <= S_FIN; end
              default:   begin state <= S_FIN; end
            endcase
          end
        end
        S_FIN: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      dt         <= dt_next;
      cmd_w      <= pressure_phase ? CMD_CONVERT_TEMP : CMD_CONVERT_PRESSURE;
      was_pres_w <= pressure_phase;
    end
    if (state == S_WAIT && mul_done) begin
      case (pass)
        PASS_TEMP: temp_w <= TEMP_W'(prod_scaled + base_term);
        PASS_OFF:  off_w  <= OFF_W'(prod_scaled + base_term);
        PASS_SENS: sens_w <= MCAND_W'(prod_scaled + base_term);
        PASS_PRES: diff_w <= prod_scaled + base_term;
        default: ;
      endcase
    end
    if (state == S_FIN) begin
      pres_w <= PRES_W'(div_pow2(diff_w, P2_SHIFT));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_PUSH && (!out_valid || out_ready)) begin
      next_command        <= cmd_w;
      sample_was_pressure <= was_pres_w;
      temp_centideg       <= temp_w;
      pressure_pa         <= pres_w;
    end
  end

  `ASSERT_AT(a_phase_flips, clk, rst,
             (in_valid && in_ready) |=> (pressure_phase != $past(pressure_phase)),
             "phase did not flip")
  `ASSERT_AT(a_done_in_wait, clk, rst, mul_done |-> (state == S_WAIT),
             "multiplier finished outside wait")
  `ASSERT_AT(a_out_from_push, clk, rst, $rose(out_valid) |-> $past(state == S_PUSH),
             "result without push")
  `ASSERT_AT(a_cmd_matches, clk, rst,
             out_valid |-> (sample_was_pressure == (next_command == CMD_CONVERT_TEMP)),
             "command and slot disagree")

endmodule

`default_nettype wire

// ===== verif/bptc_result_check.sv =====
`timescale 1ns / 100ps
// Result check for baro_pressure_temp_compensation: watches the request, result and
// register channels and predicts every result from its own state and register copy.
// Depends on bptc_pkg; instantiated beside the block by baro_pressure_temp_compensation_tb.

module bptc_result_check
  import bptc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [SAMPLE_W-1:0]         adc_sample,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [CMD_W-1:0]            next_command,
  input  logic                        sample_was_pressure,
  input  logic signed [TEMP_W-1:0]    temp_centideg,
  input  logic signed [PRES_W-1:0]    pressure_pa,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]           cfg_data,
  output int                          mismatches,
  output int                          outstanding
);

  // Scale factors and divisors of the compensation; every division truncates toward zero
  localparam longint TEMP_DIV   = 64'sd1 <<< TEMP_SHIFT;
  localparam longint OFF_SCALE  = 64'sd1 <<< OFF_SHIFT;
  localparam longint OFF_T_DIV  = 64'sd1 <<< OFF_T_SHIFT;
  localparam longint SENS_SCALE = 64'sd1 <<< SENS_SHIFT;
  localparam longint SENS_T_DIV = 64'sd1 <<< SENS_T_SHIFT;
  localparam longint P1_DIV     = 64'sd1 <<< P1_SHIFT;
  localparam longint P2_DIV     = 64'sd1 <<< P2_SHIFT;
  localparam longint REF_SCALE  = 64'sd1 <<< REF_SHIFT;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              was_pressure;
    logic [TEMP_W-1:0] temp;
    logic [PRES_W-1:0] pres;
  } reading_t;

  reading_t expected_readings[$];

  // Own copy of the block state and calibration words
  logic                phase_pres;
  logic [SAMPLE_W-1:0] raw_p;
  logic [SAMPLE_W-1:0] raw_t;
  logic [COEF_W-1:0]   c_sens, c_off, c_sens_t, c_off_t, c_ref, c_slope;

  // Store the sample in its slot, flip the phase, then run first-order compensation
  function automatic reading_t compensate(input logic [SAMPLE_W-1:0] sample);
    reading_t r;
    longint d1, d2, k1, k2, k3, k4, k5, k6;
    longint dt, t, off, sens, p;
    if (phase_pres) begin
      raw_p          = sample;
      r.cmd          = CMD_CONVERT_TEMP;
      r.was_pressure = 1'b1;
      phase_pres     = 1'b0;
    end else begin
      raw_t          = sample;
      r.cmd          = CMD_CONVERT_PRESSURE;
      r.was_pressure = 1'b0;
      phase_pres     = 1'b1;
    end
    // unsigned vectors zero-extend into the 64-bit signed working values
    d1 = longint'(raw_p);
    d2 = longint'(raw_t);
    k1 = longint'(c_sens);
    k2 = longint'(c_off);
    k3 = longint'(c_sens_t);
    k4 = longint'(c_off_t);
    k5 = longint'(c_ref);
    k6 = longint'(c_slope);
    dt   = d2 - k5 * REF_SCALE;
    t    = longint'(TEMP_BASE) + (dt * k6) / TEMP_DIV;
    off  = k2 * OFF_SCALE + (k4 * dt) / OFF_T_DIV;
    sens = k1 * SENS_SCALE + (k3 * dt) / SENS_T_DIV;
    p    = (d1 * sens / P1_DIV - off) / P2_DIV;
    r.temp = t[TEMP_W-1:0];
    r.pres = p[PRES_W-1:0];
    return r;
  endfunction

  // Results are compared before this edge's request is predicted: a result taken
  // now always belongs to an older request
  always @(posedge clk) begin : watch
    reading_t got;
    reading_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      phase_pres = 1'b0;
      raw_p      = '0;
      raw_t      = '0;
      c_sens     = '0;
      c_off      = '0;
      c_sens_t   = '0;
      c_off_t    = '0;
      c_ref      = '0;
      c_slope    = '0;
      expected_readings.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // result channel
      if (out_valid && out_ready) begin
        got = {next_command, sample_was_pressure, temp_centideg, pressure_pa};
        if (expected_readings.size() == 0) begin
          $error("result with no request pending: next_command %0h", next_command);
          errs++;
        end else begin
          want = expected_readings.pop_front();
          if (got.cmd !== want.cmd) begin
            $error("next_command: expected %0h, got %0h", want.cmd, got.cmd);
            errs++;
          end
          if (got.was_pressure !== want.was_pressure) begin
            $error("sample_was_pressure: expected %0b, got %0b",
                   want.was_pressure, got.was_pressure);
            errs++;
          end
          if (got.temp !== want.temp) begin
            $error("temp_centideg: expected %0d, got %0d",
                   $signed(want.temp), $signed(got.temp));
            errs++;
          end
          if (got.pres !== want.pres) begin
            $error("pressure_pa: expected %0d, got %0d",
                   $signed(want.pres), $signed(got.pres));
            errs++;
          end
        end
      end
      // register channel; indexes past the last register are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENS:        c_sens   = cfg_data;
          REG_OFFSET:      c_off    = cfg_data;
          REG_SENS_TEMP:   c_sens_t = cfg_data;
          REG_OFFSET_TEMP: c_off_t  = cfg_data;
          REG_REF_TEMP:    c_ref    = cfg_data;
          REG_TEMP_SLOPE:  c_slope  = cfg_data;
          default: ;
        endcase
      end
      // request channel
      if (in_valid && in_ready)
        expected_readings.push_back(compensate(adc_sample));
      mismatches  <= mismatches + errs;
      outstanding <= expected_readings.size();
    end
  end

endmodule

// ===== verif/baro_pressure_temp_compensation_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for baro_pressure_temp_compensation: drives requests, calibration
// writes and result back-pressure, and gives the verdict.
// Depends on bptc_pkg, the block and bptc_result_check.

module baro_pressure_temp_compensation_tb;
  import bptc_pkg::*;

  // Indexes past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 265;
  localparam int HOLD_PHASE      = 2;
  localparam int GAPLESS_PHASE   = 4;
  localparam int HOLD_CYCLES     = 400;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [SAMPLE_W-1:0]      adc_sample;
  logic                     out_valid;
  logic                     out_ready;
  logic [CMD_W-1:0]         next_command;
  logic                     sample_was_pressure;
  logic signed [TEMP_W-1:0] temp_centideg;
  logic signed [PRES_W-1:0] pressure_pa;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [COEF_W-1:0]        cfg_data;
  int                       mismatches;
  int                       outstanding;
  logic                     hold_req;
  logic                     hold_done;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  baro_pressure_temp_compensation DUT (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .adc_sample          (adc_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .next_command        (next_command),
    .sample_was_pressure (sample_was_pressure),
    .temp_centideg       (temp_centideg),
    .pressure_pa         (pressure_pa),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  bptc_result_check result_check (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .adc_sample          (adc_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .next_command        (next_command),
    .sample_was_pressure (sample_was_pressure),
    .temp_centideg       (temp_centideg),
    .pressure_pa         (pressure_pa),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  // Offer one request and hold it until taken; valid is left high
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    in_valid   <= 1'b1;
    adc_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // All six calibration words, then both unused indexes with junk data
  task automatic load_coefs(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6,
                            input logic [COEF_W-1:0] spare);
    write_reg(REG_SENS, c1);
    write_reg(REG_OFFSET, c2);
    write_reg(REG_SENS_TEMP, c3);
    write_reg(REG_OFFSET_TEMP, c4);
    write_reg(REG_REF_TEMP, c5);
    write_reg(REG_TEMP_SLOPE, c6);
    write_reg(REG_SPARE_A, spare);
    write_reg(REG_SPARE_B, ~spare);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every predicted result has come out, then a short settle
  task automatic drain;
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample;
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return SAMPLE_W'($urandom);
      default:    return SAMPLE_W'($urandom_range(6000000, 10000000));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] draw_coef;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(20000, 45000));
    endcase
  endfunction

  // Bursts of random length with random gaps; max_gap of zero keeps valid up
  task automatic stream_samples(input int count, input int max_gap);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_sample(draw_sample());
      left -= burst;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Result back-pressure: segments of random mode, plus one long hold on request
  initial begin : receiver
    int mode;
    int span;
    int tick;
    tick = 0;
    out_ready <= 1'b0;
    hold_done <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 3 != 2);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    in_valid   <= 1'b0;
    adc_sample <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    hold_req   <= 1'b0;
    rst        <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration; the first result uses the empty pressure slot
    send_sample(24'hFFFFFF);
    send_sample(24'h000000);
    in_valid <= 1'b0;
    drain();

    // typical factory words, realistic readings then field extremes
    load_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312, 16'h0000);
    send_sample(24'd8569150);
    send_sample(24'd9085466);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'hFFFFFF);
    send_sample(24'h000000);
    send_sample(24'hAAAAAA);
    send_sample(24'h555555);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
    in_valid <= 1'b0;
    drain();

    // every word at its maximum
    load_coefs('1, '1, '1, '1, '1, '1, 16'hFFFF);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'hFFFFFF);
    send_sample(24'hFFFFFF);
    in_valid <= 1'b0;
    drain();

    // no base terms, largest temperature terms: deepest negative offsets
    load_coefs('0, '0, '1, '1, '1, '1, 16'h5A5A);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    in_valid <= 1'b0;
    drain();

    // random calibration phases
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_coefs(draw_coef(), draw_coef(), draw_coef(), draw_coef(), draw_coef(),
                 draw_coef(), COEF_W'($urandom));
      if (ph == HOLD_PHASE) hold_req <= 1'b1;
      stream_samples(ITEMS_PER_PHASE, (ph == GAPLESS_PHASE) ? 0 : 20);
      drain();
    end

    repeat (64) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("baro_pressure_temp_compensation: match");
    else
      $display("baro_pressure_temp_compensation: mismatch");
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #10000000;
    $display("baro_pressure_temp_compensation: mismatch");
    $finish;
  end

endmodule
